// File: design/mch_pkg.sv
`default_nettype none
package mch_pkg;

  // Defaults for the top-level parameters.
  localparam int SCALE_FRAC_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 24;

  // Datapath widths.
  localparam int MAG_W    = 49;
  localparam int NORM_W   = 31;
  localparam int SQ_W     = 60;
  localparam int SUMSQ_W  = 62;
  localparam int SPAN_W   = 16;
  localparam int SPSUM_W  = 18;
  localparam int BIAS_W   = 17;
  localparam int TICK_W   = 17;
  localparam int STEP_W   = 5;
  localparam int VEC_W    = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Action codes.
  localparam logic [1:0] ACT_MEASURE = 2'd0;
  localparam logic [1:0] ACT_CALIB   = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 1'b1;

  // Reset values and limits.
  localparam logic signed [15:0] EXT_MAX_INIT = -16'sd10000;
  localparam logic signed [15:0] EXT_MIN_INIT = 16'sd10000;
  localparam logic [15:0] CAL_COUNT_RST = 16'd1000;
  localparam logic [15:0] STALE_RST     = 16'd200;
  localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd1686629713;
  localparam logic [16:0] HEAD_MAX = 17'd25736;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } mch_in_t;

  typedef struct packed {
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic signed [15:0] heading;
    logic               healthy;
    logic               calibration_done;
  } mch_out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic shr;
    logic shl;
    logic sqr;
    logic div_unit;
    logic div_scale;
  } lane_ctrl_t;

  // Arctangent of 2^-i with 30 fractional bits.
  function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] idx);
    case (idx)
      5'd0:  return 30'd843314857;
      5'd1:  return 30'd497837829;
      5'd2:  return 30'd263043837;
      5'd3:  return 30'd133525159;
      5'd4:  return 30'd67021687;
      5'd5:  return 30'd33543516;
      5'd6:  return 30'd16775851;
      5'd7:  return 30'd8388437;
      5'd8:  return 30'd4194283;
      5'd9:  return 30'd2097149;
      5'd10: return 30'd1048576;
      5'd11: return 30'd524288;
      5'd12: return 30'd262144;
      5'd13: return 30'd131072;
      5'd14: return 30'd65536;
      5'd15: return 30'd32768;
      5'd16: return 30'd16384;
      5'd17: return 30'd8192;
      5'd18: return 30'd4096;
      5'd19: return 30'd2048;
      5'd20: return 30'd1024;
      5'd21: return 30'd512;
      5'd22: return 30'd256;
      5'd23: return 30'd128;
      default: return 30'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: design/mch_lane.sv
`default_nettype none
module mch_lane #(
  parameter int SCALE_FRAC_BITS = mch_pkg::SCALE_FRAC_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mch_pkg::lane_ctrl_t           ctrl,
  input  wire logic signed [15:0]            raw,
  input  wire logic signed [mch_pkg::BIAS_W-1:0] bias_twice,
  input  wire logic [31:0]                   scale,
  input  wire logic [mch_pkg::NORM_W-1:0]    norm,
  input  wire logic [mch_pkg::SPSUM_W-1:0]   span_sum,
  input  wire logic [mch_pkg::SPAN_W-1:0]    span,
  output logic [mch_pkg::MAG_W-1:0]          mag,
  output logic                               neg,
  output logic [mch_pkg::SQ_W-1:0]           sq,
  output logic                               div_busy,
  output logic signed [15:0]                 unit,
  output logic [31:0]                        new_scale
);
  import mch_pkg::*;

  localparam int NUM_W = 19 + SCALE_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic signed [15:0]  raw_r;
  logic                neg_r;
  logic [MAG_W-1:0]    mag_r;
  logic [SQ_W-1:0]     sq_r;
  logic [NORM_W-1:0]   rem_r;
  logic [NORM_W-1:0]   den_r;
  logic [NUM_W-1:0]    num_r;
  logic [NUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic signed [17:0]  diff;
  logic signed [50:0]  prod;
  logic [50:0]         prod_abs;
  logic [45:0]         unit_num;
  logic [SPSUM_W-1:0]  scale_den;
  logic [NUM_W-1:0]    scale_num;
  logic [NORM_W:0]     rem_try;
  logic                rem_ge;
  logic [15:0]         uq;
  logic [NUM_W+31:0]   quo_ext;

  // Offset correction and soft-iron gain, both exact in integers.
  assign diff     = {raw_r[15], raw_r, 1'b0} - {bias_twice[BIAS_W-1], bias_twice};
  assign prod     = diff * $signed({1'b0, scale});
  assign prod_abs = prod[50] ? 51'(-prod) : 51'(prod);

  // Dividend of the unit component, rounded half up.
  assign unit_num = {1'b0, mag_r[29:0], 15'b0} + 46'(norm >> 1);

  // Dividend and divisor of the new gain.
  assign scale_den = {1'b0, span, 1'b0} + {2'b00, span};
  assign scale_num = (NUM_W'(span_sum) << SCALE_FRAC_BITS) + NUM_W'(scale_den >> 1);

  // One restoring division step per cycle.
  assign rem_try = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = rem_try >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw_r <= raw;
    end
    if (ctrl.mul) begin
      mag_r <= prod_abs[MAG_W-1:0];
      neg_r <= prod[50];
    end else if (ctrl.shr) begin
      mag_r <= mag_r >> 1;
    end else if (ctrl.shl) begin
      mag_r <= mag_r << 1;
    end
    if (ctrl.sqr) begin
      sq_r <= mag_r[29:0] * mag_r[29:0];
    end
  end

  // Divider shared by the unit component and the gain update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.div_unit) begin
      cnt_r <= CNT_W'(16);
    end else if (ctrl.div_scale) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_unit) begin
      rem_r <= {1'b0, unit_num[45:16]};
      den_r <= norm;
      num_r <= {unit_num[15:0], {(NUM_W-16){1'b0}}};
      quo_r <= '0;
    end else if (ctrl.div_scale) begin
      rem_r <= '0;
      den_r <= NORM_W'(scale_den);
      num_r <= scale_num;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_ge ? NORM_W'(rem_try - {1'b0, den_r}) : rem_try[NORM_W-1:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[NUM_W-2:0], rem_ge};
    end
  end

  // Clamp the unit component and restore its sign; saturate the gain.
  assign uq        = quo_r[15] ? 16'd32767 : quo_r[15:0];
  assign quo_ext   = {32'b0, quo_r};
  assign unit      = neg_r ? $signed(16'(~uq + 16'd1)) : $signed(uq);
  assign new_scale = (|quo_ext[NUM_W+31:32]) ? 32'hFFFF_FFFF : quo_ext[31:0];
  assign mag       = mag_r;
  assign neg       = neg_r;
  assign sq        = sq_r;
  assign div_busy  = cnt_r != '0;

endmodule
`default_nettype wire

// File: design/mch_isqrt.sv
`default_nettype none
module mch_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mch_pkg::SUMSQ_W-1:0]  radicand,
  output logic                              busy,
  output logic [mch_pkg::NORM_W-1:0]        root
);
  import mch_pkg::*;

  logic [SUMSQ_W-1:0] n_r;
  logic [SUMSQ_W-1:0] r_r;
  logic [SUMSQ_W-1:0] bit_r;
  logic [SUMSQ_W-1:0] trial;

  // Digit-by-digit floor square root, one result bit per cycle.
  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (start) begin
      bit_r <= SUMSQ_W'(1) << (SUMSQ_W - 2);
    end else if (bit_r != '0) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= radicand;
      r_r <= '0;
    end else if (bit_r != '0) begin
      if (n_r >= trial) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

  assign busy = bit_r != '0;
  assign root = r_r[NORM_W-1:0];

endmodule
`default_nettype wire

// File: design/mch_cordic.sv
`default_nettype none
module mch_cordic #(
  parameter int CORDIC_STEPS = mch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [mch_pkg::VEC_W-1:0] x_in,
  input  wire logic signed [mch_pkg::VEC_W-1:0] y_in,
  output logic                                  busy,
  output logic signed [15:0]                    heading
);
  import mch_pkg::*;

  localparam int RUN = (CORDIC_STEPS < CORDIC_MAX_STEPS) ? CORDIC_STEPS : CORDIC_MAX_STEPS;

  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic [STEP_W-1:0]  i_r;
  logic               run_r;
  logic               zero_r;
  logic signed [33:0] x_ext;
  logic signed [33:0] y_ext;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] ang;
  logic [32:0]        z_mag;
  logic [16:0]        z_rnd;
  logic [15:0]        z_clip;

  assign x_ext = 34'(x_in);
  assign y_ext = 34'(y_in);
  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign ang   = $signed({3'b000, atan_entry(i_r)});

  // Step counter and run flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      i_r   <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      i_r   <= '0;
    end else if (run_r) begin
      i_r <= i_r + 1'b1;
      if (i_r == STEP_W'(RUN - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Pre-rotation into the right half plane, then vectoring steps.
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r <= y_ext;
          y_r <= -x_ext;
          z_r <= ANG_HALF_PI;
        end else begin
          x_r <= -y_ext;
          y_r <= x_ext;
          z_r <= -ANG_HALF_PI;
        end
      end else begin
        x_r <= x_ext;
        y_r <= y_ext;
        z_r <= '0;
      end
    end else if (run_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end
    end
  end

  // Round the angle half away from zero to Q3.13 and clamp to pi.
  assign z_mag  = z_r[32] ? 33'(-z_r) : 33'(z_r);
  assign z_rnd  = 17'((z_mag + 33'd65536) >> 17);
  assign z_clip = (z_rnd > HEAD_MAX) ? HEAD_MAX[15:0] : z_rnd[15:0];
  assign heading = zero_r ? 16'sd0 :
                   (z_r[32] ? $signed(16'(~z_clip + 16'd1)) : $signed(z_clip));
  assign busy = run_r;

endmodule
`default_nettype wire

// File: design/magnetometer_calibrate_heading.sv
`default_nettype none
// Magnetometer hard/soft-iron correction with unit vector and heading.
// Input channel (in_valid, in_stall, in_data): one transfer per item, either
// a measure sample, a calibration sample or a one millisecond tick. Output
// channel (out_valid, out_stall, out_data): exactly one result per item, in
// order. Configuration (cfg_we, cfg_index, cfg_wdata) writes the calibration
// count and the stale limit; the user must write them only while the block
// is idle, as the block itself does not enforce it. A tick or unused action
// code goes straight to the finish state after the transfer. A sample takes a
// multiply, single-bit normalizing shifts until the largest magnitude has its
// top bit at bit 29, squaring and sum, 31 square-root steps in parallel with
// the CORDIC, and 16 division steps in the three axis lanes. A sample that
// completes a calibration run also runs the gain divisions in the lanes. One
// item is worked on at a time; the next transfer is taken while a finished
// result still waits in the output register. A stalled output holds its
// result and the block holds the next one until the register frees up.
// Reset restores the register defaults, unit gains, zero offsets, the
// calibration extremes and a zero held vector and heading.
module magnetometer_calibrate_heading #(
  parameter int SCALE_FRAC_BITS = mch_pkg::SCALE_FRAC_DEF,
  parameter int CORDIC_STEPS    = mch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mch_pkg::mch_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mch_pkg::mch_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mch_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mch_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_MUL  = 11'b000_0000_0010,
    ST_NORM = 11'b000_0000_0100,
    ST_SQR  = 11'b000_0000_1000,
    ST_SUM  = 11'b000_0001_0000,
    ST_ROOT = 11'b000_0010_0000,
    ST_DGO  = 11'b000_0100_0000,
    ST_DIV  = 11'b000_1000_0000,
    ST_SGO  = 11'b001_0000_0000,
    ST_SWT  = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]              cal_count_r;
  logic [15:0]              stale_r;
  logic signed [15:0]       mx_r [3];
  logic signed [15:0]       mn_r [3];
  logic signed [BIAS_W-1:0] bias_r [3];
  logic signed [BIAS_W-1:0] pend_bias_r [3];
  logic [SPAN_W-1:0]        span_r [3];
  logic [31:0]              scale_r [3];
  logic [15:0]              seen_r;
  logic [TICK_W-1:0]        ticks_r;
  logic signed [15:0]       held_r [3];
  logic signed [15:0]       head_r;
  logic                     fire_r;
  logic                     out_valid_r;
  mch_out_t                 out_data_r;

  lane_ctrl_t               ctrl;
  logic                     in_acc;
  logic                     out_free;
  logic                     root_start;
  logic signed [15:0]       raw_in [3];
  logic signed [15:0]       mx_n [3];
  logic signed [15:0]       mn_n [3];
  logic [15:0]              seen_n;
  logic [15:0]              need;
  logic                     fire_n;
  logic [MAG_W-1:0]         mag [3];
  logic                     neg [3];
  logic [SQ_W-1:0]          sq [3];
  logic                     lane_busy [3];
  logic signed [15:0]       unit [3];
  logic [31:0]              nscale [3];
  logic signed [VEC_W-1:0]  svec [3];
  logic [MAG_W-1:0]         big_xy;
  logic [MAG_W-1:0]         big;
  logic [SPSUM_W-1:0]       span_sum;
  logic                     span_ok;
  logic                     any_busy;
  logic [SUMSQ_W-1:0]       sumsq;
  logic [NORM_W-1:0]        norm;
  logic                     sqrt_busy;
  logic                     cordic_busy;
  logic signed [15:0]       cordic_head;

  assign in_stall  = state_r != ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign raw_in[0] = in_data.raw_x;
  assign raw_in[1] = in_data.raw_y;
  assign raw_in[2] = in_data.raw_z;

  // Extremes and run count as a calibration sample would leave them.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mx_n[a] = (raw_in[a] > mx_r[a]) ? raw_in[a] : mx_r[a];
      mn_n[a] = (raw_in[a] < mn_r[a]) ? raw_in[a] : mn_r[a];
    end
  end
  assign seen_n = seen_r + 16'd1;
  assign need   = (cal_count_r == '0) ? 16'd1 : cal_count_r;
  assign fire_n = seen_n >= need;

  // Merge of the lane magnitudes: the largest sets the normalizing shift.
  assign big_xy = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign big    = (big_xy > mag[2]) ? big_xy : mag[2];

  assign sumsq    = SUMSQ_W'(sq[0]) + SUMSQ_W'(sq[1]) + SUMSQ_W'(sq[2]);
  assign span_sum = SPSUM_W'(span_r[0]) + SPSUM_W'(span_r[1]) + SPSUM_W'(span_r[2]);
  assign span_ok  = (span_r[0] != '0) && (span_r[1] != '0) && (span_r[2] != '0);
  assign any_busy = lane_busy[0] || lane_busy[1] || lane_busy[2];

  // Per-axis lanes.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign svec[g] = neg[g] ? -$signed({1'b0, mag[g][29:0]}) : $signed({1'b0, mag[g][29:0]});

    mch_lane #(
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .raw        (raw_in[g]),
      .bias_twice (bias_r[g]),
      .scale      (scale_r[g]),
      .norm       (norm),
      .span_sum   (span_sum),
      .span       (span_r[g]),
      .mag        (mag[g]),
      .neg        (neg[g]),
      .sq         (sq[g]),
      .div_busy   (lane_busy[g]),
      .unit       (unit[g]),
      .new_scale  (nscale[g])
    );
  end

  mch_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sumsq),
    .busy     (sqrt_busy),
    .root     (norm)
  );

  mch_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .x_in    (svec[0]),
    .y_in    (svec[1]),
    .busy    (cordic_busy),
    .heading (cordic_head)
  );

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    ctrl       = '0;
    root_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          if (in_data.action == ACT_MEASURE || in_data.action == ACT_CALIB) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (big == '0) begin
          state_nxt = fire_r ? ST_SGO : ST_FIN;
        end else if (|big[MAG_W-1:30]) begin
          ctrl.shr = 1'b1;
        end else if (!big[29]) begin
          ctrl.shl = 1'b1;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        ctrl.sqr  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sqrt_busy && !cordic_busy) begin
          state_nxt = ST_DGO;
        end
      end
      ST_DGO: begin
        ctrl.div_unit = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!any_busy) begin
          state_nxt = fire_r ? ST_SGO : ST_FIN;
        end
      end
      ST_SGO: begin
        if (span_ok) begin
          ctrl.div_scale = 1'b1;
          state_nxt      = ST_SWT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SWT: begin
        if (!any_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r <= CAL_COUNT_RST;
      stale_r     <= STALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_COUNT:   cal_count_r <= cfg_wdata;
        REG_STALE_LIMIT: stale_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Calibration state, staleness counter and held results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      ticks_r <= '0;
      fire_r  <= 1'b0;
      head_r  <= '0;
      for (int a = 0; a < 3; a++) begin
        mx_r[a]    <= EXT_MAX_INIT;
        mn_r[a]    <= EXT_MIN_INIT;
        bias_r[a]  <= '0;
        scale_r[a] <= 32'd1 << SCALE_FRAC_BITS;
        held_r[a]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Item transfer: staleness and the calibration run bookkeeping.
      if (in_acc) begin
        fire_r <= 1'b0;
        if (in_data.action == ACT_TICK) begin
          if (ticks_r != TICK_MAX) begin
            ticks_r <= ticks_r + 1'b1;
          end
        end else if (in_data.action == ACT_MEASURE || in_data.action == ACT_CALIB) begin
          ticks_r <= '0;
        end
        if (in_data.action == ACT_CALIB) begin
          if (fire_n) begin
            seen_r <= '0;
            fire_r <= 1'b1;
            for (int a = 0; a < 3; a++) begin
              pend_bias_r[a] <= BIAS_W'(mx_n[a]) + BIAS_W'(mn_n[a]);
              span_r[a]      <= SPAN_W'(BIAS_W'(mx_n[a]) - BIAS_W'(mn_n[a]));
              mx_r[a]        <= EXT_MAX_INIT;
              mn_r[a]        <= EXT_MIN_INIT;
            end
          end else begin
            seen_r <= seen_n;
            for (int a = 0; a < 3; a++) begin
              mx_r[a] <= mx_n[a];
              mn_r[a] <= mn_n[a];
            end
          end
        end
      end

      // The new offsets take effect once this sample's correction is done.
      if (state_r == ST_MUL && fire_r) begin
        for (int a = 0; a < 3; a++) begin
          bias_r[a] <= pend_bias_r[a];
        end
      end

      // Zero vector: unit fields and heading all zero.
      if (state_r == ST_NORM && big == '0) begin
        head_r <= '0;
        for (int a = 0; a < 3; a++) begin
          held_r[a] <= '0;
        end
      end

      if (state_r == ST_DIV && !any_busy) begin
        head_r <= cordic_head;
        for (int a = 0; a < 3; a++) begin
          held_r[a] <= unit[a];
        end
      end

      if (state_r == ST_SWT && !any_busy) begin
        for (int a = 0; a < 3; a++) begin
          scale_r[a] <= nscale[a];
        end
      end

      if (state_r == ST_FIN && out_free) begin
        fire_r <= 1'b0;
      end
    end
  end

  // Output register: loaded when the result is done and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r.unit_x           <= held_r[0];
      out_data_r.unit_y           <= held_r[1];
      out_data_r.unit_z           <= held_r[2];
      out_data_r.heading          <= head_r;
      out_data_r.healthy          <= ticks_r <= {1'b0, stale_r};
      out_data_r.calibration_done <= fire_r;
    end
  end

endmodule
`default_nettype wire
